### design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared types, codes and default sizes for the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Default sizes for the top-level parameters.
   localparam int MaxFrameDefault  = 100;
   localparam int TypeCountDefault = 256;

   // Field widths fixed by the link protocol.
   localparam int ByteW   = 8;
   localparam int LengthW = 7;
   localparam int StatusW = 3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FIRST_HEADER   = 2'd0;
   localparam logic [1:0] CSR_SECOND_HEADER  = 2'd1;
   localparam logic [1:0] CSR_TAIL_VALUE     = 2'd2;
   localparam logic [1:0] CSR_RECEIVE_ENABLE = 2'd3;

   // Item commands.
   localparam logic CMD_LINK_BYTE   = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   // Parser phase.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_HEAD1 = 2'd1,
      PH_HEAD2 = 2'd2,
      PH_DATA  = 2'd3
   } phase_type;

   // Result status codes.
   typedef enum logic [StatusW-1:0] {
      ST_BUSY     = 3'd0,
      ST_GOOD     = 3'd1,
      ST_BADSUM   = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_REJECT   = 3'd4
   } status_type;

   // One result item.
   typedef struct packed {
      status_type         status;
      logic [LengthW-1:0] frame_length;
      logic [ByteW-1:0]   computed_sum;
   } result_type;

   // Requests from the parser to the length table.
   typedef struct packed {
      logic               wr_en;
      logic [ByteW-1:0]   wr_index;
      logic [LengthW-1:0] wr_length;
      logic               rd_en;
      logic [ByteW-1:0]   rd_index;
   } table_req_type;

endpackage

### design/serial_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// Serial frame receiver core
// Parses header, type, data, checksum and tail frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a received link byte (command 0) or a write of
//   one length table entry (command 1). rsp_* returns exactly one result item
//   per accepted item, in order. csr_* writes the header, tail and enable
//   registers and is always ready; write it only while the block is idle.
// Latency and throughput:
//   The result of an item is presented on rsp_* in the cycle after it is
//   accepted. One item is accepted per cycle unless a result is stalled; the
//   parser and checksum update in one step, accept edge to result register.
// Reset:
//   The parser returns to idle, the registers take their reset values and the
//   length table reads as all zero at once through per-entry valid bits, so
//   items are accepted as soon as reset is released.
// Stall:
//   While a result waits and rsp_ready is low, req_ready is low and the
//   result is held unchanged. When rsp_ready is high a new item is accepted
//   in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module serial_frame_receiver_core #(
   parameter int MAX_FRAME  = sfr_pkg::MaxFrameDefault,
   parameter int TYPE_COUNT = sfr_pkg::TypeCountDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [sfr_pkg::ByteW-1:0]    req_link_byte,
   input  logic [sfr_pkg::ByteW-1:0]    req_entry_index,
   input  logic [sfr_pkg::LengthW-1:0]  req_entry_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sfr_pkg::StatusW-1:0]  rsp_status,
   output logic [sfr_pkg::LengthW-1:0]  rsp_frame_length,
   output logic [sfr_pkg::ByteW-1:0]    rsp_computed_sum,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [sfr_pkg::ByteW-1:0]    csr_data
);
   import sfr_pkg::*;

   logic [ByteW-1:0]   first_header_ff;
   logic [ByteW-1:0]   second_header_ff;
   logic [ByteW-1:0]   tail_value_ff;
   logic               receive_enable_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_result_ff;
   result_type         result;
   table_req_type      table_req;
   logic [LengthW-1:0] expected_length;
   logic               step;

   // Handshakes: the result register frees up when it is taken.
   assign csr_ready    = 1'b1;
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign step         = req_valid && req_ready;
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_header_ff   <= '0;
         second_header_ff  <= '0;
         tail_value_ff     <= '0;
         receive_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FIRST_HEADER:   first_header_ff   <= csr_data;
            CSR_SECOND_HEADER:  second_header_ff  <= csr_data;
            CSR_TAIL_VALUE:     tail_value_ff     <= csr_data;
            CSR_RECEIVE_ENABLE: receive_enable_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   sfr_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .command         (req_command),
      .link_byte       (req_link_byte),
      .entry_index     (req_entry_index),
      .entry_length    (req_entry_length),
      .first_header    (first_header_ff),
      .second_header   (second_header_ff),
      .tail_value      (tail_value_ff),
      .receive_enable  (receive_enable_ff),
      .expected_length (expected_length),
      .table_req       (table_req),
      .result          (result)
   );

   sfr_len_table #(
      .TYPE_COUNT (TYPE_COUNT)
   ) u_len_table (
      .clock           (clock),
      .reset           (reset),
      .table_req       (table_req),
      .expected_length (expected_length)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_result_ff.status;
   assign rsp_frame_length = rsp_result_ff.frame_length;
   assign rsp_computed_sum = rsp_result_ff.computed_sum;

endmodule

### design/sfr_len_table.sv
// ----------------------------------------------------------------------------
// Frame length table
// One entry per frame type holding the expected total frame length. Entries
// never written read as zero through per-entry valid bits cleared at reset.
// The read is registered and holds until the next lookup.
// ----------------------------------------------------------------------------
module sfr_len_table #(
   parameter int TYPE_COUNT = sfr_pkg::TypeCountDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sfr_pkg::table_req_type       table_req,
   output logic [sfr_pkg::LengthW-1:0]  expected_length
);
   import sfr_pkg::*;

   localparam int IdxW = $clog2(TYPE_COUNT);

   logic [LengthW-1:0]  mem [TYPE_COUNT];
   logic [TYPE_COUNT-1:0] valid_ff;
   logic [LengthW-1:0]  rd_length_ff;
   logic                rd_hit_ff;
   logic                rd_hit_in;
   logic                wr_in_range;
   logic                rd_in_range;
   logic [IdxW-1:0]     wr_addr;
   logic [IdxW-1:0]     rd_addr;

   // Indexes at or beyond the type count are ignored on write and miss on read.
   assign wr_in_range = {1'b0, table_req.wr_index} < 9'(TYPE_COUNT);
   assign rd_in_range = {1'b0, table_req.rd_index} < 9'(TYPE_COUNT);
   assign wr_addr     = table_req.wr_index[IdxW-1:0];
   assign rd_addr     = table_req.rd_index[IdxW-1:0];
   assign rd_hit_in   = rd_in_range && valid_ff[rd_addr];

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (table_req.wr_en && wr_in_range) begin
         mem[wr_addr] <= table_req.wr_length;
      end
      if (table_req.rd_en) begin
         rd_length_ff <= mem[rd_addr];
      end
   end

   // Valid bits and the hit flag of the last lookup.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (table_req.wr_en && wr_in_range) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (table_req.rd_en) begin
            rd_hit_ff <= rd_hit_in;
         end
      end
   end

   assign expected_length = rd_hit_ff ? rd_length_ff : '0;

endmodule

### design/sfr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Steps the header, type and data phases one item at a time, keeps the byte
// count and running checksum, and forms the result of each item.
// ----------------------------------------------------------------------------
module sfr_parser #(
   parameter int MAX_FRAME = sfr_pkg::MaxFrameDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         command,
   input  logic [sfr_pkg::ByteW-1:0]    link_byte,
   input  logic [sfr_pkg::ByteW-1:0]    entry_index,
   input  logic [sfr_pkg::LengthW-1:0]  entry_length,
   input  logic [sfr_pkg::ByteW-1:0]    first_header,
   input  logic [sfr_pkg::ByteW-1:0]    second_header,
   input  logic [sfr_pkg::ByteW-1:0]    tail_value,
   input  logic                         receive_enable,
   input  logic [sfr_pkg::LengthW-1:0]  expected_length,
   output sfr_pkg::table_req_type       table_req,
   output sfr_pkg::result_type          result
);
   import sfr_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [LengthW-1:0] count_ff, count_in;
   logic [ByteW-1:0]   sum_ff, sum_in;
   logic [ByteW-1:0]   prev_ff, prev_in;
   logic               link_step;
   logic [LengthW-1:0] next_count;
   logic               frame_close;
   logic               overflow;

   // Decoded conditions for the current item.
   assign link_step   = step && (command == CMD_LINK_BYTE) && receive_enable;
   assign next_count  = count_ff + 7'd1;
   assign frame_close = (link_byte == tail_value) && (next_count == expected_length);
   assign overflow    = next_count >= 7'(MAX_FRAME);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (link_step) begin
         case (phase_ff)
            PH_IDLE:  phase_in = (link_byte == first_header) ? PH_HEAD1 : PH_IDLE;
            PH_HEAD1: phase_in = (link_byte == second_header) ? PH_HEAD2 : PH_IDLE;
            PH_HEAD2: phase_in = PH_DATA;
            PH_DATA:  phase_in = (frame_close || overflow) ? PH_IDLE : PH_DATA;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // Datapath updates, table requests and the result of this item.
   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      prev_in   = prev_ff;
      table_req = '{wr_en: step && (command == CMD_TABLE_WRITE),
                    wr_index: entry_index, wr_length: entry_length,
                    rd_en: 1'b0, rd_index: link_byte};
      result    = '{status: ST_BUSY, frame_length: count_ff, computed_sum: '0};
      if (link_step) begin
         case (phase_ff)
            PH_IDLE: begin
               count_in = (link_byte == first_header) ? 7'd1 : 7'd0;
               result.status = (link_byte == first_header) ? ST_BUSY : ST_REJECT;
               result.frame_length = count_in;
            end
            PH_HEAD1: begin
               count_in = (link_byte == second_header) ? 7'd2 : 7'd0;
               result.status = (link_byte == second_header) ? ST_BUSY : ST_REJECT;
               result.frame_length = count_in;
            end
            PH_HEAD2: begin
               // The type byte: look up its length and start the checksum.
               count_in = 7'd3;
               sum_in   = '0;
               prev_in  = link_byte;
               table_req.rd_en = 1'b1;
               result.frame_length = count_in;
            end
            PH_DATA: begin
               if (frame_close) begin
                  // The byte before the tail is the checksum.
                  count_in = '0;
                  result.status = (sum_ff == prev_ff) ? ST_GOOD : ST_BADSUM;
                  result.frame_length = next_count;
                  result.computed_sum = sum_ff;
               end else if (overflow) begin
                  count_in = '0;
                  result.status = ST_OVERFLOW;
                  result.frame_length = next_count;
               end else begin
                  count_in = next_count;
                  sum_in   = sum_ff + prev_ff;
                  prev_in  = link_byte;
                  result.frame_length = next_count;
               end
            end
            default: begin
               count_in = '0;
            end
         endcase
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         prev_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         prev_ff  <= prev_in;
      end
   end

`ifndef SYNTHESIS
   // The count always matches the phase outside the data phase.
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> count_ff == 7'd0)
      else $error("parser idle with a non-zero byte count");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEAD1 |-> count_ff == 7'd1) and
      (phase_ff == PH_HEAD2 |-> count_ff == 7'd2))
      else $error("header phase and byte count disagree");

   // A frame in progress never holds MAX_FRAME bytes or more.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (count_ff >= 7'd3) && (count_ff < 7'(MAX_FRAME)))
      else $error("data phase byte count out of range");

   // Any closing or rejecting result returns the parser to idle.
   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      step && (result.status != ST_BUSY) |=> phase_ff == PH_IDLE)
      else $error("parser did not return to idle after a frame ended");
`endif

endmodule
